// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/wavpcm_pkg.sv =====
package wavpcm_pkg;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_DEPTH   = 3'd1,
    ST_BAD_CODEC   = 3'd2,
    ST_PARTIAL     = 3'd3,
    ST_BAD_CHANNEL = 3'd4
  } status_e;

  localparam logic [1:0] REG_CODEC    = 2'd0;
  localparam logic [1:0] REG_BITS     = 2'd1;
  localparam logic [1:0] REG_CHANNELS = 2'd2;

  localparam logic [15:0] CODEC_PCM   = 16'd1;
  localparam logic [15:0] CODEC_FLOAT = 16'd3;

  typedef struct packed {
    logic [15:0] codec_tag;
    logic [5:0]  sample_bits;
    logic [3:0]  channel_count;
  } cfg_t;

  typedef struct packed {
    logic [15:0] sample_value;
    logic [2:0]  channel_index;
    logic        frame_end;
    logic        stream_end;
    status_e     status;
  } result_t;

  // IEEE single to int16: clamp to [-1,1] (NaN -> 1), times 32767 with RNE, truncate.
  function automatic logic [15:0] float_to_s16(input logic [31:0] w);
    logic        sgn;
    logic [7:0]  ex;
    logic [23:0] m;
    logic [38:0] prod;
    logic [7:0]  sh;
    logic [39:0] full;
    logic [23:0] r;
    logic [15:0] mag;
    logic        guard;
    logic        sticky;
    logic [38:0] smask;
    logic [15:0] res;
    begin
      sgn  = w[31];
      ex   = w[30:23];
      m    = {1'b1, w[22:0]};
      res  = 16'd0;
      if ((ex == 8'hFF && w[22:0] != 23'd0) || ex >= 8'd127) begin
        if (ex == 8'hFF && w[22:0] != 23'd0) res = 16'd32767;
        else res = sgn ? 16'h8001 : 16'd32767;
      end else if (ex < 8'd103) begin
        res = 16'd0;
      end else begin
        // value = m * 2^(ex-150); product with 32767 (15 bits)
        prod = 39'(m) * 39'd32767;
        // product has 38 or 39 bits; normalize to 24-bit mantissa with RNE
        if (prod[38]) begin
          r      = prod[38:15];
          guard  = prod[14];
          sticky = |prod[13:0];
          smask  = 39'd0;
          sh     = 8'd15;
        end else begin
          r      = prod[37:14];
          guard  = prod[13];
          sticky = |prod[12:0];
          smask  = 39'd0;
          sh     = 8'd14;
        end
        full = 40'(r) + 40'((guard && (sticky || r[0])) ? 1 : 0);
        // rounded value = full * 2^(sh + ex - 150); ex < 127, so the exponent is negative: shift right
        mag = 16'(full >> (8'd150 - ex - sh));
        if (smask != 39'd0) mag = 16'd0;
        res = sgn ? 16'(-$signed({1'b0, mag})) : mag;
      end
      return res;
    end
  endfunction

endpackage

// ===== rtl/wavpcm_cfg.sv =====
module wavpcm_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  output wavpcm_pkg::cfg_t  cfg_o
);
  wavpcm_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        wavpcm_pkg::REG_CODEC:    cfg_d.codec_tag     = cfg_data_i;
        wavpcm_pkg::REG_BITS:     cfg_d.sample_bits   = cfg_data_i[5:0];
        wavpcm_pkg::REG_CHANNELS: cfg_d.channel_count = cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.codec_tag     <= wavpcm_pkg::CODEC_PCM;
      cfg_q.sample_bits   <= 6'd16;
      cfg_q.channel_count <= 4'd2;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
endmodule

// ===== rtl/wavpcm_core.sv =====
`include "assert_macros.svh"
module wavpcm_core #(
  parameter int unsigned MaxChannels = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wavpcm_pkg::cfg_t     cfg_i,
  input  logic                 in_fire_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  output logic                 res_valid_o,
  output wavpcm_pkg::result_t  res_o
);
  logic [23:0] gather_q, gather_d;
  logic [1:0]  bpos_q, bpos_d;
  logic [2:0]  chpos_q, chpos_d;

  wavpcm_pkg::status_e st;
  logic [1:0]  bps_m1;
  logic        sample_done, frame_done;
  logic [31:0] word;
  logic [15:0] value;

  always_comb begin
    if (cfg_i.channel_count == 4'd0 || 32'(cfg_i.channel_count) > MaxChannels)
      st = wavpcm_pkg::ST_BAD_CHANNEL;
    else if (cfg_i.sample_bits != 6'd8 && cfg_i.sample_bits != 6'd16 &&
             cfg_i.sample_bits != 6'd24 && cfg_i.sample_bits != 6'd32)
      st = wavpcm_pkg::ST_BAD_DEPTH;
    else if (cfg_i.codec_tag != wavpcm_pkg::CODEC_PCM &&
             cfg_i.codec_tag != wavpcm_pkg::CODEC_FLOAT)
      st = wavpcm_pkg::ST_BAD_CODEC;
    else
      st = wavpcm_pkg::ST_OK;
  end

  assign bps_m1      = cfg_i.sample_bits[4:3] - 2'd1;
  assign sample_done = bpos_q >= bps_m1;
  assign frame_done  = {1'b0, chpos_q} >= (cfg_i.channel_count - 4'd1);

  // Merge the closing byte over the gathered ones; a depth change mid-sample
  // can leave earlier bytes in the same lane.
  always_comb begin
    word = {8'd0, gather_q};
    case (bps_m1)
      2'd0:    word[7:0]   = gather_q[7:0]   | data_byte_i;
      2'd1:    word[15:8]  = gather_q[15:8]  | data_byte_i;
      2'd2:    word[23:16] = gather_q[23:16] | data_byte_i;
      default: word[31:24] = data_byte_i;
    endcase
  end

  always_comb begin
    case (cfg_i.sample_bits)
      6'd8:    value = {word[7] ^ 1'b1, word[6:0], 8'd0};
      6'd16:   value = word[15:0];
      6'd24:   value = word[23:8];
      default: value = (cfg_i.codec_tag == wavpcm_pkg::CODEC_FLOAT) ?
                       wavpcm_pkg::float_to_s16(word) : word[31:16];
    endcase
  end

  wavpcm_pkg::result_t r;
  logic                rv;

  always_comb begin
    gather_d = gather_q;
    bpos_d   = bpos_q;
    chpos_d  = chpos_q;
    rv       = 1'b0;
    r        = '{16'd0, 3'd0, 1'b0, 1'b1, wavpcm_pkg::ST_PARTIAL};
    if (in_fire_i) begin
      if (st != wavpcm_pkg::ST_OK) begin
        r.status = st;
        rv = last_byte_i;
      end else if (!sample_done) begin
        case (bpos_q)
          2'd0:    gather_d[7:0]   = gather_d[7:0]   | data_byte_i;
          2'd1:    gather_d[15:8]  = gather_d[15:8]  | data_byte_i;
          default: gather_d[23:16] = gather_d[23:16] | data_byte_i;
        endcase
        bpos_d = bpos_q + 2'd1;
        rv = last_byte_i;
      end else begin
        gather_d = 24'd0;
        bpos_d   = 2'd0;
        chpos_d  = frame_done ? 3'd0 : chpos_q + 3'd1;
        rv = 1'b1;
        if (!(last_byte_i && !frame_done))
          r = '{value, chpos_q, frame_done, last_byte_i, wavpcm_pkg::ST_OK};
      end
      if (last_byte_i) begin
        gather_d = 24'd0;
        bpos_d   = 2'd0;
        chpos_d  = 3'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gather_q <= 24'd0;
      bpos_q   <= 2'd0;
      chpos_q  <= 3'd0;
    end else begin
      gather_q <= gather_d;
      bpos_q   <= bpos_d;
      chpos_q  <= chpos_d;
    end
  end

  assign res_valid_o = rv;
  assign res_o       = r;

  `ASSERT_NEXT(a_last_clears, clk_i, rst_ni, in_fire_i && last_byte_i,
               bpos_q == 2'd0 && chpos_q == 3'd0 && gather_q == 24'd0)
  `ASSERT_IMPL(a_err_zero, clk_i, rst_ni, rv && r.status != wavpcm_pkg::ST_OK,
               r.sample_value == 16'd0 && r.stream_end)
  `ASSERT_IMPL(a_res_needs_in, clk_i, rst_ni, rv, in_fire_i)
endmodule

// ===== rtl/wav_sample_to_pcm16_unit.sv =====
// WAV data-chunk byte stream to signed 16-bit PCM samples.
// Input channel (s_axis_*): one payload byte per transfer, tlast = last byte
// of the chunk. Output channel (m_axis_*): one converted sample per transfer,
// tdata = sample value, tlast = stream end, tuser = channel, frame end, status.
// Configuration channel (cfg_*): index 0 codec tag, 1 bits per sample,
// 2 channel count; write only while the stream is idle.
// Throughput: one byte per cycle while s_axis_tready is high; the byte that
// completes a sample (or the flagged last byte) yields its result in the
// output register in the next cycle. Conversion, including float scaling,
// is one combinational pass between the position/gather registers and the result register.
// When the receiver stalls, the result register holds and s_axis_tready
// stays high only if that register is empty or drains in the same cycle.
// Reset restores codec 1, 16 bits, two channels and clears all positions
// and the output valid flag.
`include "assert_macros.svh"
module wav_sample_to_pcm16_unit #(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] sample_value
  output logic        m_axis_tlast,   // stream_end
  output logic [7:0]  m_axis_tuser,   // [2:0] channel_index, [3] frame_end,
                                      // [6:4] status, [7] zero
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  wavpcm_pkg::cfg_t    cfg;
  wavpcm_pkg::result_t res, out_q;
  logic                res_valid, in_fire, out_v_q;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_v_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  wavpcm_cfg u_cfg (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_index_i, .cfg_data_i, .cfg_o(cfg)
  );

  wavpcm_core #(.MaxChannels(MAX_CHANNELS)) u_core (
    .clk_i, .rst_ni, .cfg_i(cfg), .in_fire_i(in_fire),
    .data_byte_i(s_axis_tdata), .last_byte_i(s_axis_tlast),
    .res_valid_o(res_valid), .res_o(res)
  );

  // Output register: load on a new result, drop after a transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_v_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && res_valid) out_q <= res;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q.sample_value;
  assign m_axis_tlast  = out_q.stream_end;
  assign m_axis_tuser  = {1'b0, out_q.status, out_q.frame_end, out_q.channel_index};

  `ASSERT_NEXT(a_hold_stall, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
               m_axis_tvalid && $stable(m_axis_tdata))
  `ASSERT_IMPL(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)
endmodule

// ===== bench/wav_sample_to_pcm16_unit_tb.sv =====
module wav_sample_to_pcm16_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0]         value;
    logic [2:0]          ch;
    logic                fe;
    logic                se;
    wavpcm_pkg::status_e st;
  } pcm_out_t;

  // Shadow of the converter: format settings, stream positions and the
  // queue of samples still owed by the block.
  class pcm_scoreboard;
    logic [15:0] codec;
    logic [5:0]  bits;
    logic [3:0]  chans;
    logic [23:0] gather;
    logic [1:0]  byte_pos;
    logic [2:0]  chan_pos;
    pcm_out_t    owed[$];
    int          errors;

    function new();
      codec = wavpcm_pkg::CODEC_PCM;
      bits = 6'd16;
      chans = 4'd2;
      gather = '0;
      byte_pos = '0;
      chan_pos = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        wavpcm_pkg::REG_CODEC:    codec = data;
        wavpcm_pkg::REG_BITS:     bits = data[5:0];
        wavpcm_pkg::REG_CHANNELS: chans = data[3:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function wavpcm_pkg::status_e format_status();
      if (chans == 0 || chans > 8) return wavpcm_pkg::ST_BAD_CHANNEL;
      if (!(bits == 8 || bits == 16 || bits == 24 || bits == 32))
        return wavpcm_pkg::ST_BAD_DEPTH;
      if (codec != wavpcm_pkg::CODEC_PCM && codec != wavpcm_pkg::CODEC_FLOAT)
        return wavpcm_pkg::ST_BAD_CODEC;
      return wavpcm_pkg::ST_OK;
    endfunction

    // Clamp to [-1,1] (NaN to 1), scale by 32767 with single-precision
    // round to nearest even, then truncate toward zero.
    function logic [15:0] scale_float(logic [31:0] w);
      logic [7:0]  ex;
      logic [63:0] prod;
      logic [63:0] r;
      int          s;
      logic        guard;
      logic        sticky;
      logic [15:0] mag;
      ex = w[30:23];
      if (ex == 8'hFF && w[22:0] != 0) return 16'd32767;
      if (ex >= 8'd127) return w[31] ? 16'h8001 : 16'd32767;
      if (ex < 8'd103) return 16'd0;
      prod = {40'd0, 1'b1, w[22:0]} * 64'd32767;
      s = prod[38] ? 15 : 14;
      r = prod >> s;
      guard = prod[s-1];
      sticky = (prod & ((64'd1 << (s - 1)) - 1)) != 0;
      if (guard && (sticky || r[0])) r = r + 1;
      mag = 16'(r >> (150 - ex - s));
      return w[31] ? -mag : mag;
    endfunction

    function logic [15:0] to_pcm16(logic [31:0] w);
      case (bits)
        6'd8:  return {w[7:0] ^ 8'h80, 8'h00};
        6'd16: return w[15:0];
        6'd24: return w[23:8];
        default: return (codec == wavpcm_pkg::CODEC_FLOAT) ? scale_float(w) : w[31:16];
      endcase
    endfunction

    // Note one accepted payload byte; queue the sample it completes, if any.
    function void note_byte(logic [7:0] b, logic last);
      wavpcm_pkg::status_e st;
      logic [2:0]          nbytes;
      logic [31:0]         word;
      logic                frame_done;
      pcm_out_t            r;
      st = format_status();
      r = '{16'd0, 3'd0, 1'b0, 1'b1, wavpcm_pkg::ST_PARTIAL};
      if (st != wavpcm_pkg::ST_OK) begin
        if (!last) return;
        gather = '0; byte_pos = '0; chan_pos = '0;
        r.st = st;
        owed.insert(owed.size(), r);
        return;
      end
      nbytes = bits[5:3];
      if (32'(byte_pos) < 32'(nbytes) - 1) begin
        gather = gather | (24'(b) << (8 * byte_pos));
        byte_pos = byte_pos + 1;
        if (!last) return;
        gather = '0; byte_pos = '0; chan_pos = '0;
        owed.insert(owed.size(), r);
        return;
      end
      word = {8'd0, gather} | (32'(b) << (8 * (nbytes - 1)));
      frame_done = 32'(chan_pos) >= 32'(chans) - 1;
      r = '{to_pcm16(word), chan_pos, frame_done, last, wavpcm_pkg::ST_OK};
      gather = '0;
      byte_pos = '0;
      chan_pos = frame_done ? 3'd0 : chan_pos + 1;
      if (last) begin
        chan_pos = '0;
        if (!frame_done) r = '{16'd0, 3'd0, 1'b0, 1'b1, wavpcm_pkg::ST_PARTIAL};
      end
      owed.insert(owed.size(), r);
    endfunction

    function void check(logic [15:0] value, logic [7:0] user, logic tlast);
      pcm_out_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected sample value=%h user=%h last=%b", $time, value, user,
                 tlast);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (value !== e.value) begin
        $display("%0t: sample value expected %h actual %h", $time, e.value, value);
        errors++;
      end
      if (user[2:0] !== e.ch) begin
        $display("%0t: channel expected %0d actual %0d", $time, e.ch, user[2:0]);
        errors++;
      end
      if (user[3] !== e.fe) begin
        $display("%0t: frame end expected %b actual %b", $time, e.fe, user[3]);
        errors++;
      end
      if (tlast !== e.se) begin
        $display("%0t: stream end expected %b actual %b", $time, e.se, tlast);
        errors++;
      end
      if (user[6:4] !== e.st) begin
        $display("%0t: status expected %0d actual %0d", $time, e.st, user[6:4]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [7:0]  m_axis_tuser;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  pcm_scoreboard sb = new();
  int burst_left = 0;
  int bytes_sent = 0;

  wav_sample_to_pcm16_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Receiver: switch between stall patterns at random intervals so that
  // long runs with no backpressure alternate with heavy stalling.
  initial begin
    int mode;
    int left;
    m_axis_tready = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(10, 60);
      end
      left--;
      case (mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 1) == 1);
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= (left % 4 != 0);
      endcase
    end
  end

  // Sample results on the falling edge before the rising edge that completes the transfer.
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  // Send one payload byte; open a new burst after a random gap when the
  // current burst is used up.
  task automatic send_byte(logic [7:0] b, logic last);
    logic ok;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    do begin
      @(negedge clk_i);
      ok = s_axis_tready;
      @(posedge clk_i);
    end while (!ok);
    sb.note_byte(b, last);
    burst_left--;
    bytes_sent++;
  endtask

  // Drain: hold the input idle until every owed sample has left the block.
  task automatic drain();
    int guard_cnt;
    s_axis_tvalid <= 1'b0;
    guard_cnt = 0;
    while (sb.pending() != 0 && guard_cnt < 20000) begin
      @(posedge clk_i);
      guard_cnt++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Present one register write and wait for its transfer; the caller drops
  // cfg_valid_i after the last write.
  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    logic ok;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do begin
      @(negedge clk_i);
      ok = cfg_ready_o;
      @(posedge clk_i);
    end while (!ok);
    sb.set_reg(idx, data);
  endtask

  task automatic set_format(logic [15:0] codec, logic [5:0] bits, logic [3:0] chans);
    drain();
    write_reg(wavpcm_pkg::REG_CODEC, codec);
    write_reg(wavpcm_pkg::REG_BITS, {10'd0, bits});
    write_reg(wavpcm_pkg::REG_CHANNELS, {12'd0, chans});
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_float();
    case ($urandom_range(0, 9))
      0: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom)};
      1: return {$urandom_range(0, 1) == 1, 8'd127, 23'd0};
      2, 3: return $urandom;
      default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(100, 128)),
                       23'($urandom)};
    endcase
  endfunction

  // One chunk: whole frames of random samples, sometimes cut short to leave
  // a partial final frame; under bad settings just a few loose bytes.
  task automatic send_chunk();
    logic [7:0]  q[$];
    logic [31:0] w;
    int nb;
    int frames;
    int cut;
    if (sb.format_status() != wavpcm_pkg::ST_OK) begin
      repeat ($urandom_range(1, 8)) q.insert(q.size(), 8'($urandom));
    end else begin
      nb = sb.bits / 8;
      frames = $urandom_range(1, 6);
      repeat (frames * sb.chans) begin
        w = (sb.codec == wavpcm_pkg::CODEC_FLOAT && sb.bits == 32) ? rand_float() :
            $urandom;
        for (int i = 0; i < nb; i++) q.insert(q.size(), w[8*i +: 8]);
      end
      if ($urandom_range(0, 5) == 0) begin
        cut = $urandom_range(1, nb * sb.chans - 1 > 0 ? nb * sb.chans - 1 : 1);
        if (cut < q.size()) repeat (cut) void'(q.pop_back());
      end
    end
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  task automatic send_words(logic [31:0] words[$], int nb);
    foreach (words[k])
      for (int i = 0; i < nb; i++)
        send_byte(words[k][8*i +: 8], k == words.size() - 1 && i == nb - 1);
  endtask

  initial begin
    logic [31:0] fw[$];
    logic [31:0] pw[$];
    logic [15:0] codecs[5];
    logic [5:0]  depths[7];
    logic [3:0]  chan_opts[6];
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = wavpcm_pkg::REG_CODEC;
    cfg_data_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: float specials (NaN, -inf, just under 1, denormal, tiny),
    // 8-bit extremes, then an extensible codec tag and a chunk cut mid-frame.
    fw = '{32'h7FC00000, 32'hFF800000, 32'h3F7FFFFF, 32'h00000001, 32'h38000100,
           32'hBF800000};
    set_format(wavpcm_pkg::CODEC_FLOAT, 6'd32, 4'd1);
    send_words(fw, 4);
    pw = '{32'h00, 32'hFF, 32'h80, 32'h7F};
    set_format(wavpcm_pkg::CODEC_PCM, 6'd8, 4'd1);
    send_words(pw, 1);
    set_format(16'hFFFE, 6'd16, 4'd2);
    send_byte(8'h55, 1'b1);
    set_format(wavpcm_pkg::CODEC_PCM, 6'd16, 4'd2);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h01, 1'b1);

    codecs = '{wavpcm_pkg::CODEC_PCM, wavpcm_pkg::CODEC_FLOAT, 16'd0, 16'hFFFF,
               16'hFFFE};
    depths = '{6'd8, 6'd16, 6'd24, 6'd32, 6'd0, 6'd63, 6'd12};
    chan_opts = '{4'd1, 4'd2, 4'd3, 4'd8, 4'd0, 4'd15};
    while (bytes_sent < 830) begin
      if ($urandom_range(0, 7) == 0)
        set_format(codecs[$urandom_range(0, 4)], depths[$urandom_range(0, 6)],
                   chan_opts[$urandom_range(0, 5)]);
      else
        set_format(codecs[$urandom_range(0, 1)], depths[$urandom_range(0, 3)],
                   chan_opts[$urandom_range(0, 3)]);
      repeat ($urandom_range(1, 3)) send_chunk();
    end
    drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
